FILE: rtl/core/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// shared types and constants of the cross gradient block: pixel word,
// configuration register map and pipeline control bundle
// ----------------------------------------------------------------------------
package pcg_pkg;

	localparam int PIX_W      = 24;
	localparam int CHAN_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int DIST_W   = 3;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;

	localparam logic [DIST_W-1:0]   DIST_RST   = 3'd1;
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DISTANCE     = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic emit;
		logic interior;
		logic frame_end;
	} s1_ctrl_t;

endpackage

FILE: rtl/core/pcg_pixel_if.sv
// ----------------------------------------------------------------------------
// pcg_pixel_if
// input pixel channel: valid/ready handshake with one raster pixel per request
// ----------------------------------------------------------------------------
interface pcg_pixel_if;
	logic          valid;
	logic          ready;
	pcg_pkg::pix_t pixel_in;
	logic          frame_start;

	modport source (output valid, output pixel_in, output frame_start, input ready);
	modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

FILE: rtl/core/pcg_grad_if.sv
// ----------------------------------------------------------------------------
// pcg_grad_if
// output gradient channel: valid/ready handshake with one result per request
// ----------------------------------------------------------------------------
interface pcg_grad_if;
	logic          valid;
	logic          ready;
	pcg_pkg::pix_t pixel_out;
	logic          interior;
	logic          frame_end;

	modport source (output valid, output pixel_out, output interior, output frame_end,
		input ready);
	modport sink   (input valid, input pixel_out, input interior, input frame_end,
		output ready);
endinterface

FILE: rtl/core/pixel_cross_gradient.sv
// ----------------------------------------------------------------------------
// pixel_cross_gradient
// cross-shaped central difference gradient on a BGR raster pixel stream
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output side takes results
// and no bank recompute is running, and gives the result for position
// (r, c) when the pixel of row r+distance, column c arrives: a synchronous
// line memory read into stage 1, then one output register. The line store
// is 2*MAX_DISTANCE row banks of MAX_WIDTH pixels, each with one write port
// and two read ports; row k lives in bank k mod 2*distance. Border positions
// come out as zero with interior low, and the last distance rows of a frame
// give no result. After a write of the distance register the bank of the
// current row is recomputed by a restoring remainder over the row counter,
// one bit per cycle: pixel requests wait until it is done.
// ----------------------------------------------------------------------------
module pixel_cross_gradient #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MAX_DISTANCE = 4,
	parameter int MAX_HEIGHT   = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pcg_pixel_if.sink                       pixel,
	pcg_grad_if.source                      grad,
	input  logic                            cfg_wen,
	input  logic [pcg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pcg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int NB   = 2 * MAX_DISTANCE;
	localparam int BW   = (NB > 1) ? $clog2(NB) : 1;
	localparam int SBW  = BW + 1;
	localparam int DW   = $clog2(MAX_DISTANCE + 1);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int SW   = $clog2(RW);
	localparam int MW   = RW + DW + 1;
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int DXW  = (DW > pcg_pkg::DIST_W) ? DW : pcg_pkg::DIST_W;
	localparam int WXW  = (CW + 1 > pcg_pkg::WIDTH_W) ? CW + 1 : pcg_pkg::WIDTH_W;
	localparam int HXW  = (RW + 1 > pcg_pkg::HEIGHT_W) ? RW + 1 : pcg_pkg::HEIGHT_W;

	// pixel helpers
	function automatic logic [9:0] chan_sum(input pcg_pkg::pix_t p);
		chan_sum = 10'(p[7:0]) + 10'(p[15:8]) + 10'(p[23:16]);
	endfunction

	function automatic pcg_pkg::pix_t sub_floor(input pcg_pkg::pix_t a,
		input pcg_pkg::pix_t b);
		pcg_pkg::pix_t r;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			if (a[k*8 +: 8] > b[k*8 +: 8])
				r[k*8 +: 8] = a[k*8 +: 8] - b[k*8 +: 8];
		end
		sub_floor = r;
	endfunction

	function automatic pcg_pkg::pix_t pair_diff(input pcg_pkg::pix_t a,
		input pcg_pkg::pix_t b);
		if (chan_sum(b) > chan_sum(a))
			pair_diff = sub_floor(b, a);
		else
			pair_diff = sub_floor(a, b);
	endfunction

	function automatic pcg_pkg::pix_t add_sat(input pcg_pkg::pix_t a,
		input pcg_pkg::pix_t b);
		pcg_pkg::pix_t r;
		logic [8:0]    s;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			s = 9'(a[k*8 +: 8]) + 9'(b[k*8 +: 8]);
			r[k*8 +: 8] = s[8] ? 8'hff : s[7:0];
		end
		add_sat = r;
	endfunction

	// configuration registers
	logic [pcg_pkg::DIST_W-1:0]   distance_q;
	logic [pcg_pkg::WIDTH_W-1:0]  image_width_q;
	logic [pcg_pkg::HEIGHT_W-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_q     <= pcg_pkg::DIST_RST;
			image_width_q  <= pcg_pkg::WIDTH_RST;
			image_height_q <= pcg_pkg::HEIGHT_RST;
		end else if (cfg_wen) begin
			unique case (pcg_pkg::cfg_idx_t'(cfg_index))
				pcg_pkg::CFG_DISTANCE:     distance_q     <= cfg_data[pcg_pkg::DIST_W-1:0];
				pcg_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[pcg_pkg::WIDTH_W-1:0];
				pcg_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[pcg_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped settings
	logic [DW-1:0] d_c;
	logic [WW-1:0] w_c;
	logic [HW-1:0] h_c;

	always_comb begin
		if (distance_q == '0)
			d_c = DW'(1);
		else if (DXW'(distance_q) > DXW'(MAX_DISTANCE))
			d_c = DW'(MAX_DISTANCE);
		else
			d_c = DW'(distance_q);

		if (image_width_q == '0)
			w_c = WW'(1);
		else if (WXW'(image_width_q) > WXW'(MAX_WIDTH))
			w_c = WW'(MAX_WIDTH);
		else
			w_c = WW'(image_width_q);

		if (image_height_q == '0)
			h_c = HW'(1);
		else if (HXW'(image_height_q) > HXW'(MAX_HEIGHT))
			h_c = HW'(MAX_HEIGHT);
		else
			h_c = HW'(image_height_q);
	end

	logic [DW:0] banks;
	assign banks = {d_c, 1'b0};

	// position state
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [BW-1:0] bank_q;

	// bank recompute after a distance write
	logic          busy_q;
	logic [RW-1:0] rem_q;
	logic [SW-1:0] step_q;
	logic [MW-1:0] div_shift;
	logic [RW-1:0] rem_nx;

	always_comb begin
		div_shift = MW'(banks) << step_q;
		if (MW'(rem_q) >= div_shift)
			rem_nx = rem_q - RW'(div_shift);
		else
			rem_nx = rem_q;
	end

	// handshake
	logic s1_valid_q;
	logic out_valid_s2;
	logic s2_free;
	logic s1_adv;
	logic acc;

	assign s2_free     = !out_valid_s2 || grad.ready;
	assign s1_adv      = s1_valid_q && s2_free;
	assign pixel.ready = !busy_q && (!s1_valid_q || s2_free);
	assign acc         = pixel.valid && pixel.ready;

	// current position and next position
	logic [CW-1:0]  col_cur;
	logic [RW-1:0]  row_cur;
	logic [BW-1:0]  bank_cur;
	logic [SBW-1:0] rbank_sum;
	logic [BW-1:0]  rbank_cur;
	logic [CW-1:0]  col_lo;
	logic [CW-1:0]  col_hi;
	logic [CW:0]    col_inc;
	logic [RW:0]    row_inc;
	logic [SBW-1:0] bank_inc;
	logic [CW-1:0]  col_nx;
	logic [RW-1:0]  row_nx;
	logic [BW-1:0]  bank_nx;
	pcg_pkg::s1_ctrl_t ctrl_cur;

	always_comb begin
		col_cur  = pixel.frame_start ? '0 : col_q;
		row_cur  = pixel.frame_start ? '0 : row_q;
		bank_cur = pixel.frame_start ? '0 : bank_q;

		rbank_sum = SBW'(bank_cur) + SBW'(d_c);
		if (rbank_sum >= SBW'(banks))
			rbank_cur = BW'(rbank_sum - SBW'(banks));
		else
			rbank_cur = BW'(rbank_sum);

		col_lo = col_cur - CW'(d_c);
		col_hi = col_cur + CW'(d_c);

		ctrl_cur.emit      = (HXW'(row_cur) >= HXW'(d_c)) && (HXW'(row_cur) < HXW'(h_c));
		ctrl_cur.interior  = (HXW'(row_cur) >= HXW'(banks)) && (WXW'(col_cur) >= WXW'(d_c))
			&& (WXW'(col_cur) + WXW'(d_c) < WXW'(w_c));
		ctrl_cur.frame_end = (HXW'(row_cur) == HXW'(h_c) - HXW'(1))
			&& (WXW'(col_cur) == WXW'(w_c) - WXW'(1));

		col_inc  = {1'b0, col_cur} + (CW+1)'(1);
		row_inc  = {1'b0, row_cur} + (RW+1)'(1);
		bank_inc = SBW'(bank_cur) + SBW'(1);
		col_nx   = CW'(col_inc);
		row_nx   = row_cur;
		bank_nx  = bank_cur;
		if (WXW'(col_inc) >= WXW'(w_c)) begin
			col_nx = '0;
			if (HXW'(row_inc) >= HXW'(h_c)) begin
				row_nx  = '0;
				bank_nx = '0;
			end else begin
				row_nx  = RW'(row_inc);
				bank_nx = (bank_inc >= SBW'(banks)) ? '0 : BW'(bank_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			bank_q <= '0;
			busy_q <= 1'b0;
			rem_q  <= '0;
			step_q <= '0;
		end else begin
			if (cfg_wen && (pcg_pkg::cfg_idx_t'(cfg_index) == pcg_pkg::CFG_DISTANCE)) begin
				busy_q <= 1'b1;
				rem_q  <= row_q;
				step_q <= SW'(RW - 1);
			end else if (busy_q) begin
				rem_q <= rem_nx;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					bank_q <= BW'(rem_nx);
				end else begin
					step_q <= step_q - SW'(1);
				end
			end else if (acc) begin
				col_q  <= col_nx;
				row_q  <= row_nx;
				bank_q <= bank_nx;
			end
		end
	end

	// row-banked line store
	pcg_pkg::pix_t rd_a_s1 [NB];
	pcg_pkg::pix_t rd_b_s1 [NB];

	for (genvar b = 0; b < NB; b++) begin : g_bank
		pcg_pkg::pix_t mem [MAX_WIDTH];
		logic [CW-1:0] addr_a;

		assign addr_a = (bank_cur == BW'(b)) ? col_cur : col_lo;

		always_ff @(posedge clk) begin
			if (acc) begin
				rd_a_s1[b] <= mem[addr_a];
				rd_b_s1[b] <= mem[col_hi];
				if (bank_cur == BW'(b))
					mem[col_cur] <= pixel.pixel_in;
			end
		end
	end

	// stage 1: memory data ready
	pcg_pkg::s1_ctrl_t ctrl_s1;
	pcg_pkg::pix_t     pix_s1;
	logic [BW-1:0]     rbank_s1;
	logic [BW-1:0]     wbank_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (acc)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctrl_s1  <= ctrl_cur;
			pix_s1   <= pixel.pixel_in;
			rbank_s1 <= rbank_cur;
			wbank_s1 <= bank_cur;
		end
	end

	pcg_pkg::pix_t left_px;
	pcg_pkg::pix_t right_px;
	pcg_pkg::pix_t top_px;
	pcg_pkg::pix_t grad_px;

	always_comb begin
		left_px  = rd_a_s1[rbank_s1];
		right_px = rd_b_s1[rbank_s1];
		top_px   = rd_a_s1[wbank_s1];
		if (ctrl_s1.interior)
			grad_px = add_sat(pair_diff(left_px, right_px), pair_diff(top_px, pix_s1));
		else
			grad_px = '0;
	end

	// stage 2: output register
	pcg_pkg::pix_t pixel_out_s2;
	logic          interior_s2;
	logic          frame_end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s2 <= 1'b0;
		else if (s2_free)
			out_valid_s2 <= s1_adv && ctrl_s1.emit;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_out_s2 <= grad_px;
			interior_s2  <= ctrl_s1.interior;
			frame_end_s2 <= ctrl_s1.frame_end;
		end
	end

	assign grad.valid     = out_valid_s2;
	assign grad.pixel_out = pixel_out_s2;
	assign grad.interior  = interior_s2;
	assign grad.frame_end = frame_end_s2;

endmodule
